// ===== hw/rtl/stl_pkg.sv =====
// Shared types and constants for the script token lexer.
// No dependencies.
package stl_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    // One result transaction
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  char_out;
        logic [8:0]  token_length;
        logic        overflow;
        logic [15:0] line_number;
        logic [15:0] column_number;
    } t_result;

    // Per-token flags
    typedef struct packed {
        logic in_comment;
        logic in_string;
        logic have_token;
        logic tok_over;
    } t_flags;

    localparam t_flags FLAGS_CLEAR = '{default: 1'b0};

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_LC_A    = 8'h61;
    localparam logic [7:0] CH_LC_Z    = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    localparam int unsigned FIFO_DEPTH = 4;

endpackage

// ===== hw/rtl/script_token_lexer.sv =====
// Script token lexer: one script byte per input transaction, token results out.
// An accepted byte's results are registered into the result queue.
// Throughput: one byte per cycle while the queue has room for two results; such a byte fills two entries.
// A four-entry result queue lets input continue while results wait to be taken.
// Reset (i_rst_n low, synchronous): line/column to 1, token state and queue cleared,
// force_upper to 0. Depends on stl_pkg and stl_core.
module script_token_lexer import stl_pkg::*; #(
    parameter int unsigned TOKEN_CAPACITY = 256,
    parameter int unsigned POSITION_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    // byte input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_in,
    input  logic        i_last_byte,
    // result output
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_char_out,
    output logic [8:0]  o_token_length,
    output logic        o_overflow,
    output logic [15:0] o_line_number,
    output logic [15:0] o_column_number
);

    // Token counter has to hold the capacity value itself.
    localparam int unsigned CNT_W = $clog2(TOKEN_CAPACITY + 1);
    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned QCNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [QCNT_W-1:0] Q_FULL  = QCNT_W'(FIFO_DEPTH);
    // Input is taken only when room remains for the worst case of two results.
    localparam logic [QCNT_W-1:0] Q_ROOM2 = QCNT_W'(FIFO_DEPTH - 2);
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    // Architectural state
    logic                     r_force_upper;
    t_flags                   r_flags,  n_flags;
    logic [CNT_W-1:0]         r_count,  n_count;
    logic [POSITION_BITS-1:0] r_line,   n_line;
    logic [POSITION_BITS-1:0] r_col,    n_col;

    // Result queue
    t_result                  r_q [FIFO_DEPTH];
    logic [PTR_W-1:0]         r_wr_ptr;
    logic [PTR_W-1:0]         r_rd_ptr;
    logic [QCNT_W-1:0]        r_qcnt;

    logic                     in_xact;
    logic                     out_xact;
    logic [1:0]               num_res;
    logic [1:0]               push_n;
    t_result                  res0, res1, head;

    assign in_xact  = i_valid && o_ready;
    assign out_xact = o_valid && i_ready;
    assign o_ready  = (r_qcnt <= Q_ROOM2);
    assign o_valid  = (r_qcnt != '0);
    assign push_n   = in_xact ? num_res : 2'd0;

    // Whole per-byte decision happens here, straight off the input port.
    stl_core #(
        .TOKEN_CAPACITY (TOKEN_CAPACITY),
        .POSITION_BITS  (POSITION_BITS),
        .CNT_W          (CNT_W)
    ) u_core (
        .i_byte        (i_byte_in),
        .i_last        (i_last_byte),
        .i_force_upper (r_force_upper),
        .i_flags       (r_flags),
        .i_count       (r_count),
        .i_line        (r_line),
        .i_col         (r_col),
        .o_flags       (n_flags),
        .o_count       (n_count),
        .o_line        (n_line),
        .o_col         (n_col),
        .o_num         (num_res),
        .o_res0        (res0),
        .o_res1        (res1)
    );

    // Config register and lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force_upper <= 1'b0;
            r_flags       <= FLAGS_CLEAR;
            r_count       <= '0;
            r_line        <= POS_ONE;
            r_col         <= POS_ONE;
        end else begin
            if (i_cfg_we) begin
                r_force_upper <= i_cfg_data;
            end
            if (in_xact) begin
                r_flags <= n_flags;
                r_count <= n_count;
                r_line  <= n_line;
                r_col   <= n_col;
            end
        end
    end

    // Queue storage: payload only, no reset
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_q[r_wr_ptr + PTR_W'(1)] <= res1;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_qcnt   <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_n);
            if (out_xact) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_qcnt <= r_qcnt + QCNT_W'(push_n) - QCNT_W'(out_xact);
        end
    end

    assign head            = r_q[r_rd_ptr];
    assign o_kind          = head.kind;
    assign o_char_out      = head.char_out;
    assign o_token_length  = head.token_length;
    assign o_overflow      = head.overflow;
    assign o_line_number   = head.line_number;
    assign o_column_number = head.column_number;

    // Checks
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= Q_FULL)
        else $error("result queue count beyond depth");

    a_q_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xact |=> r_qcnt == $past(r_qcnt) + QCNT_W'($past(num_res))
                              - QCNT_W'($past(out_xact)))
        else $error("queue count lost track of pushed results");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TOKEN_CAPACITY))
        else $error("token count exceeds capacity");

    a_pos_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0 && r_col != '0)
        else $error("line or column reached zero");

endmodule

// ===== hw/rtl/stl_core.sv =====
// Per-byte lexer step: next state and up to two results, pure combinational.
// Depends on stl_pkg.
module stl_core import stl_pkg::*; #(
    parameter int unsigned TOKEN_CAPACITY = 256,
    parameter int unsigned POSITION_BITS  = 16,
    parameter int unsigned CNT_W          = 9
) (
    input  logic [7:0]               i_byte,
    input  logic                     i_last,
    input  logic                     i_force_upper,
    input  t_flags                   i_flags,
    input  logic [CNT_W-1:0]         i_count,
    input  logic [POSITION_BITS-1:0] i_line,
    input  logic [POSITION_BITS-1:0] i_col,
    output t_flags                   o_flags,
    output logic [CNT_W-1:0]         o_count,
    output logic [POSITION_BITS-1:0] o_line,
    output logic [POSITION_BITS-1:0] o_col,
    output logic [1:0]               o_num,
    output t_result                  o_res0,
    output t_result                  o_res1
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [CNT_W-1:0]         CAP     = CNT_W'(TOKEN_CAPACITY);

    function automatic t_result make_res(
        input t_kind                     kd,
        input logic [7:0]                ch,
        input logic [CNT_W-1:0]          cnt,
        input logic                      ov,
        input logic [POSITION_BITS-1:0]  ln,
        input logic [POSITION_BITS-1:0]  cl
    );
        t_result r;
        r.kind          = kd;
        r.char_out      = ch;
        r.token_length  = 9'(cnt);
        r.overflow      = ov;
        r.line_number   = 16'(ln);
        r.column_number = 16'(cl);
        return r;
    endfunction

    t_flags                   f;
    logic [CNT_W-1:0]         cnt;
    logic [POSITION_BITS-1:0] ln;
    logic [POSITION_BITS-1:0] cl;
    logic [1:0]               k;
    logic                     skip;
    logic                     done;
    logic                     acc;
    logic                     up;
    logic [7:0]               ch;
    t_result                  res;

    always_comb begin
        f      = i_flags;
        cnt    = i_count;
        ln     = i_line;
        cl     = i_col;
        k      = 2'd0;
        skip   = 1'b0;
        done   = 1'b0;
        acc    = 1'b0;
        up     = 1'b0;
        ch     = i_byte;
        res    = '0;
        o_res0 = '0;
        o_res1 = '0;

        if (cl != POS_MAX) begin
            cl = cl + POS_ONE;
        end
        if (i_byte == CH_SLASH) begin
            f.in_comment = 1'b1;
        end

        if (!f.in_comment) begin
            if (i_byte == CH_QUOTE && !f.in_string) begin
                f.in_string = 1'b1;   // opening quote is swallowed
                skip        = 1'b1;
            end else if (i_byte == CH_QUOTE && f.have_token) begin
                done = 1'b1;          // closing quote
            end else if (!f.in_string) begin
                if (i_byte > CH_SPACE) begin
                    f.have_token = 1'b1;
                    acc          = 1'b1;
                    up           = 1'b1;
                end else if (f.have_token) begin
                    done = 1'b1;      // whitespace ends the token
                end
            end else if (i_byte >= CH_SPACE) begin
                f.have_token = 1'b1;
                acc          = 1'b1;
                up           = 1'b1;
            end
        end

        if (done) begin
            o_res0 = make_res(KIND_DONE, 8'h00, cnt, f.tok_over, ln, cl);
            k      = 2'd1;
            f      = FLAGS_CLEAR;
            cnt    = '0;
        end

        // newline bookkeeping, skipped when the newline closed a token
        if (!done && !skip && i_byte == CH_NL) begin
            if (ln != POS_MAX) begin
                ln = ln + POS_ONE;
            end
            cl           = POS_ONE;
            f.in_comment = 1'b0;
            if (f.in_string) begin
                acc = 1'b1;           // kept as is, never upper-cased
                up  = 1'b0;
            end
        end

        if (acc) begin
            if (up && i_force_upper && ch >= CH_LC_A && ch <= CH_LC_Z) begin
                ch = ch - CASE_DELTA;
            end
            if (cnt >= CAP) begin
                f.tok_over = 1'b1;
                ch         = 8'h00;
            end else begin
                cnt = cnt + CNT_W'(1);
            end
            o_res0 = make_res(KIND_BYTE, ch, cnt, f.tok_over, ln, cl);
            k      = 2'd1;
        end

        if (i_last) begin
            res = make_res(KIND_END, 8'h00, cnt, f.tok_over, ln, cl);
            if (k == 2'd0) begin
                o_res0 = res;
            end else begin
                o_res1 = res;
            end
            k   = k + 2'd1;
            f   = FLAGS_CLEAR;
            cnt = '0;
            ln  = POS_ONE;
            cl  = POS_ONE;
        end

        o_flags = f;
        o_count = cnt;
        o_line  = ln;
        o_col   = cl;
        o_num   = k;
    end

endmodule

// ===== dv/script_token_lexer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for script_token_lexer: directed and random byte streams,
// every result checked by a scoreboard class that predicts the token stream.
// Depends on stl_pkg and the script_token_lexer RTL.
module script_token_lexer_tb;
    import stl_pkg::*;

    localparam int unsigned TOKEN_CAPACITY = 256;
    localparam int unsigned POSITION_BITS  = 16;
    localparam int unsigned POS_MAX        = (1 << POSITION_BITS) - 1;
    // Covers the four-entry result queue, with margin.
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned PRINT_CAP      = 40;
    localparam logic [7:0]  CH_TAB         = 8'h09;
    localparam logic [7:0]  CH_CR          = 8'h0D;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the lexer state, turns every
    // accepted byte transaction into the results it should cause, and
    // checks output transactions against them in order.
    // ------------------------------------------------------------------
    class lexer_scoreboard;
        t_result     pending_q[$];
        int unsigned errors;
        bit          upper;
        bit          in_comment;
        bit          in_string;
        bit          have_token;
        bit          tok_over;
        int unsigned tok_cnt;
        int unsigned line_no;
        int unsigned col_no;

        function new();
            errors = 0;
            upper  = 1'b0;
            start_script();
        endfunction

        function void clear_token();
            in_comment = 1'b0;
            in_string  = 1'b0;
            have_token = 1'b0;
            tok_over   = 1'b0;
            tok_cnt    = 0;
        endfunction

        function void start_script();
            clear_token();
            line_no = 1;
            col_no  = 1;
        endfunction

        function void emit(t_kind k, logic [7:0] ch);
            t_result r;
            r.kind          = k;
            r.char_out      = ch;
            r.token_length  = 9'(tok_cnt);
            r.overflow      = tok_over;
            r.line_number   = 16'(line_no);
            r.column_number = 16'(col_no);
            pending_q.push_back(r);
        endfunction

        // Append one byte to the token; past capacity it is dropped but still reported.
        function void take(logic [7:0] ch, bit fold);
            logic [7:0] c;
            c = ch;
            if (fold && upper && c >= CH_LC_A && c <= CH_LC_Z)
                c = c - CASE_DELTA;
            if (tok_cnt >= TOKEN_CAPACITY) begin
                tok_over = 1'b1;
                emit(KIND_BYTE, 8'h00);
            end else begin
                tok_cnt++;
                emit(KIND_BYTE, c);
            end
        endfunction

        function void note_input(logic [7:0] c, logic last);
            bit ended;
            ended = 1'b0;
            if (col_no < POS_MAX)
                col_no++;
            if (c == CH_SLASH)
                in_comment = 1'b1;
            if (!in_comment) begin
                if (c == CH_QUOTE && !in_string) begin
                    // opening quote is swallowed and adds nothing to the token
                    in_string = 1'b1;
                end else begin
                    if (c == CH_QUOTE && have_token) begin
                        emit(KIND_DONE, 8'h00);
                        clear_token();
                        ended = 1'b1;
                    end
                    if (!ended) begin
                        if (!in_string) begin
                            if (c > CH_SPACE) begin
                                have_token = 1'b1;
                                take(c, 1'b1);
                            end else if (have_token) begin
                                emit(KIND_DONE, 8'h00);
                                clear_token();
                                ended = 1'b1;
                            end
                        end else if (c >= CH_SPACE) begin
                            have_token = 1'b1;
                            take(c, 1'b1);
                        end
                    end
                end
            end
            // a newline that closed a token is not counted
            if (!ended && c == CH_NL) begin
                if (line_no < POS_MAX)
                    line_no++;
                col_no     = 1;
                in_comment = 1'b0;
                if (in_string)
                    take(c, 1'b0);
            end
            if (last) begin
                emit(KIND_END, 8'h00);
                start_script();
            end
        endfunction

        function string fmt(t_result r);
            return $sformatf("kind=%0d char=%02h len=%0d ovf=%0b line=%0d col=%0d",
                             r.kind, r.char_out, r.token_length, r.overflow,
                             r.line_number, r.column_number);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("%0t: mismatch: %s", $time, msg);
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result %s", fmt(got)));
                return;
            end
            want = pending_q.pop_front();
            if (got.kind !== want.kind || got.char_out !== want.char_out ||
                got.token_length !== want.token_length || got.overflow !== want.overflow ||
                got.line_number !== want.line_number ||
                got.column_number !== want.column_number)
                report($sformatf("got %s, want %s", fmt(got), fmt(want)));
        endtask

        task flush_leftovers();
            if (pending_q.size() != 0)
                report($sformatf("%0d results never arrived, first %s",
                                 pending_q.size(), fmt(pending_q[0])));
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input is known from time zero.
    // ------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_data  = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [7:0]  i_byte_in   = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_char_out;
    logic [8:0]  o_token_length;
    logic        o_overflow;
    logic [15:0] o_line_number;
    logic [15:0] o_column_number;

    lexer_scoreboard sb;
    int unsigned     idle_pct   = 0;   // chance per transaction of an input gap burst
    int unsigned     stall_pct  = 0;   // chance per cycle of an output stall burst
    int unsigned     items_sent = 0;

    script_token_lexer #(
        .TOKEN_CAPACITY (TOKEN_CAPACITY),
        .POSITION_BITS  (POSITION_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_byte_in       (i_byte_in),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_char_out      (o_char_out),
        .o_token_length  (o_token_length),
        .o_overflow      (o_overflow),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the DUT hangs.
    initial begin
        #10_000_000;
        $display("script_token_lexer_tb: FAIL");
        $finish;
    end

    // Output side: random bursts with ready held low.
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    // Monitor: both channels sampled in one process at the edge, so an
    // input transaction is always noted before any result in the same step.
    always @(posedge i_clk) begin : monitor
        t_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_input(i_byte_in, i_last_byte);
            if (o_valid && i_ready) begin
                got.kind          = t_kind'(o_kind);
                got.char_out      = o_char_out;
                got.token_length  = o_token_length;
                got.overflow      = o_overflow;
                got.line_number   = o_line_number;
                got.column_number = o_column_number;
                sb.check_result(got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks. All called at a clock edge; drive with NBAs.
    // ------------------------------------------------------------------

    // One byte transaction, with an optional gap burst before it.
    // Valid stays up across back-to-back transactions.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_byte_in   <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic stop_input();
        i_valid <= 1'b0;
    endtask

    // Wait for every expected result, then let the queue settle
    // (comment or blank bytes may still be in flight with no result).
    task automatic drain_results();
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Only called with the DUT idle.
    task automatic write_upper(input bit v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.upper = v;
    endtask

    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0:       b = 8'($urandom_range(CH_LC_A, CH_LC_Z));
            1:       b = 8'($urandom_range(8'h80, 8'hFF));
            default: b = 8'($urandom_range(8'h21, 8'h7E));
        endcase
        // keep words free of comment and string starters
        if (b == CH_SLASH || b == CH_QUOTE)
            b = CH_LC_A;
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0:       b = CH_SPACE;
            1:       b = CH_NL;
            2:       b = CH_TAB;
            3:       b = CH_CR;
            4:       b = 8'h00;
            default: b = 8'($urandom_range(8'h00, CH_SPACE));
        endcase
        return b;
    endfunction

    function automatic logic [7:0] string_byte();
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0)
            return CH_NL;
        b = 8'($urandom_range(CH_SPACE, 8'h7E));
        if (b == CH_SLASH || b == CH_QUOTE)
            b = CH_SPACE;
        return b;
    endfunction

    function automatic logic [7:0] odd_byte();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = CH_QUOTE;
            1:       b = CH_SLASH;
            2:       b = CH_NL;
            default: b = CH_SPACE;
        endcase
        return b;
    endfunction

    function automatic int unsigned pick_pct();
        int unsigned p;
        case ($urandom_range(0, 2))
            0:       p = 0;
            1:       p = 20;
            default: p = 50;
        endcase
        return p;
    endfunction

    // Short hand-picked stream, run with force_upper set.
    task automatic run_directed();
        send_byte(8'h61, 1'b0);     // 'a' folds to 'A'
        send_byte(8'h7A, 1'b0);     // 'z'
        send_byte(8'h60, 1'b0);     // just below 'a', not folded
        send_byte(8'h7B, 1'b0);     // just above 'z'
        send_byte(8'hFF, 1'b0);     // high bytes count as printable
        send_byte(8'h80, 1'b0);
        send_byte(CH_SPACE, 1'b0);  // blank closes the token
        send_byte(8'h21, 1'b0);     // lowest printable
        send_byte(CH_NL, 1'b0);     // closes token, line not advanced
        send_byte(CH_NL, 1'b0);     // bare newline advances line
        send_byte(CH_QUOTE, 1'b0);  // opens string, no result
        send_byte(CH_QUOTE, 1'b0);  // quote in an empty string is kept
        send_byte(8'h71, 1'b0);     // 'q'
        send_byte(CH_NL, 1'b0);     // newline kept inside string
        send_byte(CH_SPACE, 1'b0);  // space kept inside string
        send_byte(CH_QUOTE, 1'b0);  // closes string
        send_byte(8'h00, 1'b0);     // blank with no token open
        send_byte(CH_SLASH, 1'b0);  // comment start
        send_byte(8'h78, 1'b0);
        send_byte(CH_QUOTE, 1'b0);  // ignored in comment
        send_byte(CH_NL, 1'b0);     // ends comment
        send_byte(8'h62, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h21, 1'b1);     // end of script
    endtask

    // One random lexeme; mostly well-formed, some noise.
    task automatic send_piece();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            n = $urandom_range(1, 8);
            repeat (n) send_byte(word_byte(), 1'b0);
            send_byte(blank_byte(), 1'b0);
        end else if (pick < 55) begin
            send_byte(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) send_byte(string_byte(), 1'b0);
            send_byte(CH_QUOTE, 1'b0);
        end else if (pick < 65) begin
            send_byte(CH_SLASH, 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) begin
                b = 8'($urandom_range(0, 255));
                send_byte((b == CH_NL) ? CH_QUOTE : b, 1'b0);
            end
            send_byte(CH_NL, 1'b0);
        end else if (pick < 75) begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(blank_byte(), 1'b0);
        end else if (pick < 90) begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick < 96) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(odd_byte(), 1'b0);
        end else begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic random_items(input int unsigned n);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < n) send_piece();
    endtask

    // Token longer than capacity, plain or inside a string.
    task automatic send_long_token(input int unsigned n, input bit in_str);
        send_byte(CH_NL, 1'b0);     // get out of any comment first
        if (in_str)
            send_byte(CH_QUOTE, 1'b0);
        repeat (n) send_byte(in_str ? string_byte() : word_byte(), 1'b0);
        send_byte(in_str ? CH_QUOTE : CH_SPACE, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : main
        int unsigned phase;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct  = 30;
        stall_pct = 30;
        write_upper(1'b1);
        run_directed();
        stop_input();
        drain_results();

        // Random phases, force_upper alternating, idling mix per phase.
        for (phase = 0; phase < 6; phase++) begin
            idle_pct  = pick_pct();
            stall_pct = pick_pct();
            write_upper(phase[0]);
            // string token past capacity, newlines included
            if (phase == 1)
                send_long_token(TOKEN_CAPACITY + 2, 1'b1);
            random_items(30);
            stop_input();
            drain_results();
        end

        // Closing stretch at full rate, no idling on either side.
        idle_pct  = 0;
        stall_pct = 0;
        write_upper(1'b1);
        random_items(20);
        send_byte(8'h65, 1'b1);
        stop_input();
        drain_results();

        sb.flush_leftovers();
        if (sb.errors == 0)
            $display("script_token_lexer_tb: PASS");
        else
            $display("script_token_lexer_tb: FAIL");
        $finish;
    end

endmodule
